FILE: hw/rtl/forest_depth_limit_cutter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the forest depth limit cutter.
// Each macro expects signals named clk and rst in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef FOREST_DEPTH_LIMIT_CUTTER_DEFINES_SVH
`define FOREST_DEPTH_LIMIT_CUTTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FDLC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FDLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/fdlc_pkg.sv
// ----------------------------------------------------------------------------
// fdlc_pkg
// Shared constants and command codes of the forest depth limit cutter.
// ----------------------------------------------------------------------------
`default_nettype none

package fdlc_pkg;

  // Table size and the widths that follow from it.
  localparam int NODES = 1024;
  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = IDX_W + 1;

  // Fixed field widths.
  localparam int PAR_W  = 11;
  localparam int NCNT_W = 11;
  localparam int LIM_W  = 10;
  localparam int CMD_W  = 2;

  // Stored code of a root.
  localparam logic [PAR_W-1:0] ROOT_CODE = '1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Register indexes, selected by paddr[2].
  localparam logic REG_NODE_COUNT  = 1'b0;
  localparam logic REG_DEPTH_LIMIT = 1'b1;

endpackage

`default_nettype wire

FILE: hw/rtl/fdlc_ram.sv
// ----------------------------------------------------------------------------
// fdlc_ram
// Generic single-port RAM with one write and a registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fdlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write at the addressed entry and register the read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/forest_depth_limit_cutter.sv
// ----------------------------------------------------------------------------
// forest_depth_limit_cutter
// Parent-link table of a forest that cuts chains deeper than a set limit.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Command 0
// writes parent_in to entry node_index, command 2 reads that entry back,
// command 1 runs the depth limiting over entries 0 .. node_count-1, and
// command 3 does nothing. Every command gives one result word: strobe is
// high for exactly one cycle with parent_out and done_res; the receiver
// cannot stall, so the word is taken in that cycle.
// Writes, reads and the unused command may follow back to back; the result
// appears in the cycle after the command.
// A run keeps busy high while one sequencer walks the table through three
// single-port RAMs (parent table, visited marks, chain stack). It first
// clears all the visited marks, then skips each scanned node that is
// already visited and, from each unvisited node, pushes its chain of parent
// links onto the stack and pops it back off from the root down. The result
// word follows the last scan step. The user must write node_count and
// max_depth over the APB port only while idle; the block does not enforce it.
// Reset (synchronous, rst high) returns the sequencer to idle and sets
// node_count to 1024 and max_depth to 0; table contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "forest_depth_limit_cutter_defines.svh"

module forest_depth_limit_cutter
  import fdlc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Command channel
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [CMD_W-1:0]         cmd,
  input  wire logic [IDX_W-1:0]         node_index,
  input  wire logic signed [PAR_W-1:0]  parent_in,
  // Result channel
  output logic                          strobe,
  output logic signed [PAR_W-1:0]       parent_out,
  output logic                          done_res,
  // Configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [2:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic      [31:0]              prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_LINK,
    S_POP
  } state_t;

  state_t             state;
  logic [NCNT_W-1:0]  node_count;
  logic [LIM_W-1:0]   max_depth;
  logic [CNT_W-1:0]   run_lim;
  logic [CNT_W-1:0]   scan_index;
  logic [CNT_W-1:0]   stack_pointer;
  logic [CNT_W-1:0]   depth_counter;
  logic               first;
  logic               rd_sel;
  logic [PAR_W-1:0]   out_par;
  logic               out_done;

  // RAM ports
  logic               par_we;
  logic [IDX_W-1:0]   par_addr;
  logic [PAR_W-1:0]   par_wdata;
  logic [PAR_W-1:0]   par_rdata;
  logic               vis_we;
  logic [IDX_W-1:0]   vis_addr;
  logic               vis_wdata;
  logic               vis_rdata;
  logic               stk_we;
  logic [IDX_W-1:0]   stk_addr;
  logic [IDX_W-1:0]   stk_wdata;
  logic [IDX_W-1:0]   stk_rdata;

  // Decoded conditions
  logic               accept;
  logic               cfg_write;
  logic [CNT_W-1:0]   lim_next;
  logic               scan_more;
  logic               link_ok;
  logic               push_ok;
  logic               skip;
  logic               cut;
  logic [IDX_W-1:0]   nxt;
  logic [CNT_W-1:0]   sp_m1;
  logic [CNT_W-1:0]   sp_m2;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign pready   = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Effective node count: anything above the table size acts as the size.
  assign lim_next = (CNT_W'(node_count) > CNT_W'(NODES)) ? CNT_W'(NODES)
                                                        : CNT_W'(node_count);

  assign scan_more = (scan_index < run_lim);
  assign sp_m1     = stack_pointer - CNT_W'(1);
  assign sp_m2     = stack_pointer - CNT_W'(2);

  // A stored parent is a link only when it is non-negative and in range.
  assign nxt     = par_rdata[IDX_W-1:0];
  assign link_ok = !par_rdata[PAR_W-1] && (CNT_W'(par_rdata[PAR_W-2:0]) < run_lim);
  assign push_ok = (stack_pointer < CNT_W'(NODES)) && link_ok;
  assign skip    = first && vis_rdata;
  assign cut     = (depth_counter > CNT_W'(max_depth));

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      REG_NODE_COUNT:  prdata = 32'(node_count);
      REG_DEPTH_LIMIT: prdata = 32'(max_depth);
      default:         prdata = '0;
    endcase
  end

  // Result word: a read shows the RAM output directly.
  assign parent_out = rd_sel ? par_rdata : out_par;
  assign done_res   = out_done;

  // RAM addressing per sequencer state.
  always_comb begin
    par_we    = 1'b0;
    par_addr  = node_index;
    par_wdata = parent_in;
    vis_we    = 1'b0;
    vis_addr  = scan_index[IDX_W-1:0];
    vis_wdata = 1'b0;
    stk_we    = 1'b0;
    stk_addr  = sp_m1[IDX_W-1:0];
    stk_wdata = scan_index[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        par_we = start && (cmd == CMD_WRITE);
      end
      S_CLEAR: begin
        vis_we = 1'b1;
      end
      S_SCAN: begin
        par_addr = scan_index[IDX_W-1:0];
        stk_we   = scan_more;
        stk_addr = '0;
      end
      S_LINK: begin
        if (!skip && push_ok) begin
          stk_we    = 1'b1;
          stk_addr  = stack_pointer[IDX_W-1:0];
          stk_wdata = nxt;
          par_addr  = nxt;
        end
      end
      S_POP: begin
        par_we    = cut;
        par_addr  = stk_rdata;
        par_wdata = ROOT_CODE;
        vis_we    = 1'b1;
        vis_addr  = stk_rdata;
        vis_wdata = 1'b1;
        stk_addr  = sp_m2[IDX_W-1:0];
      end
      default: begin
        par_we = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NCNT_W'(NODES);
      max_depth  <= '0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_NODE_COUNT:  node_count <= pwdata[NCNT_W-1:0];
        REG_DEPTH_LIMIT: max_depth  <= pwdata[LIM_W-1:0];
        default:         node_count <= node_count;
      endcase
    end
  end

  // Sequencer and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      strobe        <= 1'b0;
      rd_sel        <= 1'b0;
      out_done      <= 1'b0;
      out_par       <= ROOT_CODE;
      scan_index    <= '0;
      stack_pointer <= '0;
      depth_counter <= '0;
      first         <= 1'b0;
      run_lim       <= '0;
    end else begin
      strobe <= 1'b0;
      rd_sel <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (cmd)
              CMD_WRITE: begin
                strobe   <= 1'b1;
                out_par  <= parent_in;
                out_done <= 1'b1;
              end
              CMD_RUN: begin
                run_lim    <= lim_next;
                scan_index <= '0;
                state      <= S_CLEAR;
              end
              CMD_READ: begin
                strobe   <= 1'b1;
                rd_sel   <= 1'b1;
                out_done <= 1'b1;
              end
              CMD_UNUSED: begin
                strobe   <= 1'b1;
                out_par  <= ROOT_CODE;
                out_done <= 1'b0;
              end
              default: begin
                strobe <= 1'b0;
              end
            endcase
          end
        end
        // Sweep the visited marks to zero, one entry a cycle.
        S_CLEAR: begin
          if (scan_index == CNT_W'(NODES - 1)) begin
            scan_index <= '0;
            state      <= S_SCAN;
          end else begin
            scan_index <= scan_index + CNT_W'(1);
          end
        end
        // Start a chain at the next node, or finish the run.
        S_SCAN: begin
          if (scan_more) begin
            stack_pointer <= CNT_W'(1);
            first         <= 1'b1;
            state         <= S_LINK;
          end else begin
            strobe   <= 1'b1;
            out_par  <= ROOT_CODE;
            out_done <= 1'b1;
            state    <= S_IDLE;
          end
        end
        // Follow parent links upward, pushing one node a cycle.
        S_LINK: begin
          first <= 1'b0;
          if (skip) begin
            scan_index <= scan_index + CNT_W'(1);
            state      <= S_SCAN;
          end else if (push_ok) begin
            stack_pointer <= stack_pointer + CNT_W'(1);
          end else begin
            depth_counter <= '0;
            state         <= S_POP;
          end
        end
        // Pop from the root down, cutting links that run too deep.
        S_POP: begin
          depth_counter <= cut ? CNT_W'(1) : depth_counter + CNT_W'(1);
          stack_pointer <= sp_m1;
          if (stack_pointer == CNT_W'(1)) begin
            scan_index <= scan_index + CNT_W'(1);
            state      <= S_SCAN;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  fdlc_ram #(.WIDTH(PAR_W), .DEPTH(NODES)) u_parent_ram (
    .clk   (clk),
    .we    (par_we),
    .addr  (par_addr),
    .wdata (par_wdata),
    .rdata (par_rdata)
  );

  fdlc_ram #(.WIDTH(1), .DEPTH(NODES)) u_visited_ram (
    .clk   (clk),
    .we    (vis_we),
    .addr  (vis_addr),
    .wdata (vis_wdata),
    .rdata (vis_rdata)
  );

  fdlc_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .addr  (stk_addr),
    .wdata (stk_wdata),
    .rdata (stk_rdata)
  );

  // A result word is never shown while a run is in progress.
  `FDLC_ASSERT_IMPL(a_no_strobe_busy, busy, !strobe, "result word during a run")
  // A run command starts with the clearing sweep.
  `FDLC_ASSERT_NEXT(a_run_clears, accept && (cmd == CMD_RUN), state == S_CLEAR, "no clear sweep")
  // Every other command answers in the next cycle.
  `FDLC_ASSERT_NEXT(a_quick_answer, accept && (cmd != CMD_RUN), strobe, "missing result word")
  // Popping never runs on an empty stack.
  `FDLC_ASSERT_IMPL(a_pop_nonempty, state == S_POP, stack_pointer != '0, "pop from empty stack")
  // The chain stack never grows beyond the table size.
  `FDLC_ASSERT_IMPL(a_stack_bound, state == S_LINK, stack_pointer <= CNT_W'(NODES), "stack overflow")

endmodule

`default_nettype wire
